@@ hdl/serial_attribute_video_line_macros.svh @@
// assertion macros for the serial-attribute video line generator
// used by the top level; expects clk and arst_n in scope
`ifndef SERIAL_ATTRIBUTE_VIDEO_LINE_MACROS_SVH
`define SERIAL_ATTRIBUTE_VIDEO_LINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SAV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SAV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sav_pkg.sv @@
// shared types and constants for the serial-attribute video line generator
// no dependencies
package sav_pkg;

	// default geometry
	localparam int CELLS_PER_LINE_DEF = 40;
	localparam int VISIBLE_LINES_DEF  = 224;
	localparam int HIRES_LINES_DEF    = 200;

	// memory map
	localparam logic [15:0] HIRES_SCREEN_BASE  = 16'hA000;
	localparam logic [15:0] TEXT_SCREEN_BASE   = 16'hBB80;
	localparam logic [15:0] CHARSET_HIRES_BASE = 16'h9800;
	localparam logic [15:0] CHARSET_TEXT_BASE  = 16'hB400;
	localparam logic [15:0] ALT_CHARSET_OFFSET = 16'(128 * 8);

	localparam logic [2:0] INK_RESET   = 3'd7;
	localparam logic [2:0] PAPER_RESET = 3'd0;
	localparam logic [5:0] PATTERN_ALL = 6'h3F;

	// attribute groups, bits 4:3 of a control byte
	typedef enum logic [1:0] {
		ATTR_INK   = 2'd0,
		ATTR_TEXT  = 2'd1,
		ATTR_PAPER = 2'd2,
		ATTR_VIDEO = 2'd3
	} sav_attr_t;

	typedef struct packed {
		logic [15:0] fetch_address;
		logic        fetch_valid;
		logic        cell_valid;
		logic [5:0]  pattern;
		logic [2:0]  ink;
		logic [2:0]  paper;
		logic        inverse;
		logic        line_done;
	} sav_result_t;

endpackage

@@ hdl/serial_attribute_video_line.sv @@
// serial-attribute video line generator, depends on sav_pkg and the assertion macros header
// the result of an accepted request is held in the output register
// throughput: one request per cycle unless stalled; the single output register sets the rate
// input stalls only while a held result is stalled downstream
// reset (async, active low) clears the line state, ink 7, paper 0, blinking shown,
// video mode 0 and the result valid; no clearing pass
`include "serial_attribute_video_line_macros.svh"

module serial_attribute_video_line #(
	parameter int CELLS_PER_LINE = sav_pkg::CELLS_PER_LINE_DEF,
	parameter int VISIBLE_LINES  = sav_pkg::VISIBLE_LINES_DEF,
	parameter int HIRES_LINES    = sav_pkg::HIRES_LINES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  line_index,
	input  logic        blink_phase,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] fetch_address,
	output logic        fetch_valid,
	output logic        cell_valid,
	output logic [5:0]  pattern,
	output logic [2:0]  ink,
	output logic [2:0]  paper,
	output logic        inverse,
	output logic        line_done
);
	import sav_pkg::*;

	localparam logic [6:0] CELLS_W = 7'(CELLS_PER_LINE);
	localparam logic [8:0] VIS_W   = 9'(VISIBLE_LINES);
	localparam logic [8:0] HIRES_W = 9'(HIRES_LINES);
	localparam logic [15:0] CELLS_A = 16'(CELLS_PER_LINE);

	// line state
	logic [7:0]  line_q, line_d;
	logic [5:0]  col_q, col_d;
	logic [2:0]  ink_q, ink_d;
	logic [2:0]  paper_q, paper_d;
	logic [2:0]  tmode_q, tmode_d;
	logic [2:0]  vmode_q, vmode_d;
	logic [15:0] row_base_q, row_base_d;
	logic [15:0] hires_base_q, hires_base_d;
	logic [15:0] text_base_q, text_base_d;
	logic [7:0]  held_q, held_d;
	logic        awaiting_q, awaiting_d;
	logic        show_blink_q, show_blink_d;

	logic        out_valid_q;
	sav_result_t res, res_q;

	logic        in_accept;
	logic [15:0] hires_base_new, text_base_new;
	logic        start_hires, hires_here;
	logic [5:0]  blink_mask;
	logic [6:0]  col_inc;
	logic        finish;
	logic [5:0]  pat;
	logic [15:0] glyph_addr;
	logic [2:0]  rowsel;
	sav_attr_t   attr;

	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	// both candidate row bases are worked out at the start of a line
	assign hires_base_new = 16'(HIRES_SCREEN_BASE + 16'(line_index) * CELLS_A);
	assign text_base_new  = 16'(TEXT_SCREEN_BASE + 16'(line_index[7:3]) * CELLS_A);
	assign start_hires    = vmode_q[2] && ({1'b0, line_index} < HIRES_W);
	assign hires_here     = vmode_q[2] && ({1'b0, line_q} < HIRES_W);
	assign blink_mask     = (show_blink_q || !tmode_q[2]) ? PATTERN_ALL : 6'h00;
	assign col_inc        = {1'b0, col_q} + 7'd1;
	assign attr           = sav_attr_t'(data_byte[4:3]);
	assign rowsel         = tmode_q[1] ? line_q[3:1] : line_q[2:0];
	assign glyph_addr     = (vmode_q[2] ? CHARSET_HIRES_BASE : CHARSET_TEXT_BASE)
		+ (tmode_q[0] ? ALT_CHARSET_OFFSET : 16'h0000)
		+ {6'b0, data_byte[6:0], 3'b000} + {13'b0, rowsel};

	always_comb begin
		line_d       = line_q;
		col_d        = col_q;
		ink_d        = ink_q;
		paper_d      = paper_q;
		tmode_d      = tmode_q;
		vmode_d      = vmode_q;
		row_base_d   = row_base_q;
		hires_base_d = hires_base_q;
		text_base_d  = text_base_q;
		held_d       = held_q;
		awaiting_d   = awaiting_q;
		show_blink_d = show_blink_q;
		finish       = 1'b0;
		pat          = 6'h00;
		res          = '0;
		if (in_accept) begin
			if (!command) begin
				line_d       = line_index;
				show_blink_d = blink_phase;
				ink_d        = INK_RESET;
				paper_d      = PAPER_RESET;
				tmode_d      = 3'd0;
				held_d       = 8'h00;
				awaiting_d   = 1'b0;
				hires_base_d = hires_base_new;
				text_base_d  = text_base_new;
				if ({1'b0, line_index} >= VIS_W) begin
					col_d = 6'(CELLS_PER_LINE);
				end else begin
					col_d             = 6'd0;
					row_base_d        = start_hires ? hires_base_new : text_base_new;
					res.fetch_address = row_base_d;
					res.fetch_valid   = 1'b1;
				end
			end else if ({1'b0, col_q} < CELLS_W) begin
				if (awaiting_q) begin
					awaiting_d = 1'b0;
					finish     = 1'b1;
					pat        = data_byte[5:0] & blink_mask;
				end else begin
					held_d = data_byte;
					if (data_byte[6:5] == 2'b00) begin
						// control byte, shows as a blank cell
						case (attr)
							ATTR_INK:   ink_d   = data_byte[2:0];
							ATTR_TEXT:  tmode_d = data_byte[2:0];
							ATTR_PAPER: paper_d = data_byte[2:0];
							ATTR_VIDEO: begin
								vmode_d    = data_byte[2:0];
								row_base_d = (data_byte[2] && ({1'b0, line_q} < HIRES_W))
									? hires_base_q : text_base_q;
							end
							default: ink_d = ink_q;
						endcase
						finish = 1'b1;
					end else if (hires_here) begin
						finish = 1'b1;
						pat    = data_byte[5:0] & blink_mask;
					end else begin
						res.fetch_address = glyph_addr;
						res.fetch_valid   = 1'b1;
						awaiting_d        = 1'b1;
					end
				end
				if (finish) begin
					res.cell_valid = 1'b1;
					res.pattern    = pat;
					res.ink        = ink_d;
					res.paper      = paper_d;
					res.inverse    = held_d[7];
					col_d          = col_inc[5:0];
					if (col_inc >= CELLS_W) begin
						res.line_done = 1'b1;
					end else begin
						res.fetch_address = row_base_d + {10'b0, col_inc[5:0]};
						res.fetch_valid   = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q       <= 8'd0;
			col_q        <= 6'd0;
			ink_q        <= INK_RESET;
			paper_q      <= PAPER_RESET;
			tmode_q      <= 3'd0;
			vmode_q      <= 3'd0;
			row_base_q   <= 16'h0000;
			hires_base_q <= HIRES_SCREEN_BASE;
			text_base_q  <= TEXT_SCREEN_BASE;
			held_q       <= 8'h00;
			awaiting_q   <= 1'b0;
			show_blink_q <= 1'b1;
		end else begin
			line_q       <= line_d;
			col_q        <= col_d;
			ink_q        <= ink_d;
			paper_q      <= paper_d;
			tmode_q      <= tmode_d;
			vmode_q      <= vmode_d;
			row_base_q   <= row_base_d;
			hires_base_q <= hires_base_d;
			text_base_q  <= text_base_d;
			held_q       <= held_d;
			awaiting_q   <= awaiting_d;
			show_blink_q <= show_blink_d;
		end
	end

	// result register, refilled whenever it is empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign fetch_address = res_q.fetch_address;
	assign fetch_valid   = res_q.fetch_valid;
	assign cell_valid    = res_q.cell_valid;
	assign pattern       = res_q.pattern;
	assign ink           = res_q.ink;
	assign paper         = res_q.paper;
	assign inverse       = res_q.inverse;
	assign line_done     = res_q.line_done;

	`SAV_ASSERT_NOW(a_col_range, 1'b1, {1'b0, col_q} <= CELLS_W, "column past end of line")
	`SAV_ASSERT_NOW(a_glyph_in_line, awaiting_q, {1'b0, col_q} < CELLS_W, "glyph wait outside line")
	`SAV_ASSERT_NEXT(a_glyph_completes, in_accept && command && awaiting_q,
		out_valid && cell_valid, "glyph byte gave no cell")
	`SAV_ASSERT_NOW(a_line_done_form, out_valid && line_done, cell_valid && !fetch_valid,
		"end of line with fetch or without cell")
	`SAV_ASSERT_NOW(a_blank_result, out_valid && !cell_valid,
		pattern == 6'h00 && ink == 3'd0 && paper == 3'd0 && !inverse && !line_done,
		"cell fields set without a cell")

endmodule
